// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the deframer unit's checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define EPD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("epd check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define EPD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("epd check failed");

`endif

// ===== hw/rtl/epd_pkg.sv =====
package epd_pkg;

   // Width of the frame length counter
   localparam int LENGTH_BITS = 16;
   // Width used to compare the counter against the reported 16-bit range
   localparam int EXT_BITS = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

   // Framing bytes and escape codes
   localparam logic [7:0] BYTE_START = 8'hAA;
   localparam logic [7:0] BYTE_STOP  = 8'hCC;
   localparam logic [7:0] BYTE_ESC   = 8'hBB;
   localparam logic [7:0] CODE_START = 8'h55;
   localparam logic [7:0] CODE_ESC   = 8'h44;
   localparam logic [7:0] CODE_STOP  = 8'h33;

   typedef logic [LENGTH_BITS-1:0] count_type;

   localparam count_type COUNT_MAX = {LENGTH_BITS{1'b1}};

   typedef enum logic [2:0] {
      EV_PAYLOAD    = 3'd0,
      EV_COMPLETE   = 3'd1,
      EV_ABORT      = 3'd2,
      EV_STRAY_STOP = 3'd3,
      EV_BAD_ESCAPE = 3'd4
   } event_kind_type;

   // Input register contents seen by the decoder
   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } stage_type;

   // One decoded result headed for the output register
   typedef struct packed {
      logic           valid;
      event_kind_type event_kind;
      logic [7:0]     payload_byte;
      logic [15:0]    frame_length;
   } result_type;

   // Clamp the running count to the 16-bit reported length
   function automatic logic [15:0] report_len(count_type count);
      logic [EXT_BITS-1:0] ext;
      ext = EXT_BITS'(count);
      if (ext > EXT_BITS'(17'h0FFFF)) begin
         return 16'hFFFF;
      end
      return ext[15:0];
   endfunction

endpackage

// ===== hw/rtl/epd_channels.sv =====
// Raw byte channel into the deframer
interface epd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// Decoded event channel out of the deframer
interface epd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [7:0]  payload_byte;
   logic [15:0] frame_length;

   modport source (output valid, output event_kind, output payload_byte,
                   output frame_length, input ready);
   modport sink (input valid, input event_kind, input payload_byte,
                 input frame_length, output ready);
endinterface

// ===== hw/rtl/epd_in_stage.sv =====
module epd_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         in_byte,
   input  logic               advance_ok,
   output logic               advance,
   output epd_pkg::stage_type stage
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   // Advance the held item whenever the result side can take its outcome
   assign advance  = valid_ff && advance_ok;
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (in_ready) begin
         valid_in = in_valid;
         byte_in  = in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign stage.valid   = valid_ff;
   assign stage.rx_byte = byte_ff;

endmodule

// ===== hw/rtl/epd_decoder.sv =====
module epd_decoder (
   input  logic                clock,
   input  logic                reset,
   input  epd_pkg::stage_type  stage,
   input  logic                advance,
   output epd_pkg::result_type result
);

   logic                in_frame_ff, in_frame_in;
   logic                esc_ff, esc_in;
   epd_pkg::count_type  count_ff, count_in;
   epd_pkg::count_type  count_inc;
   logic [7:0]          b;

   assign b = stage.rx_byte;

   // Saturating increment of the payload count
   assign count_inc = (count_ff == epd_pkg::COUNT_MAX) ? count_ff
                                                      : count_ff + 1'b1;

   // Decode the held byte against the framing state
   always_comb begin
      in_frame_in         = in_frame_ff;
      esc_in              = esc_ff;
      count_in            = count_ff;
      result.valid        = 1'b0;
      result.event_kind   = epd_pkg::EV_PAYLOAD;
      result.payload_byte = 8'h00;
      result.frame_length = 16'h0000;
      if (b == epd_pkg::BYTE_START) begin
         if (in_frame_ff) begin
            result.valid        = 1'b1;
            result.event_kind   = epd_pkg::EV_ABORT;
            result.frame_length = epd_pkg::report_len(count_ff);
         end
         in_frame_in = 1'b1;
         esc_in      = 1'b0;
         count_in    = '0;
      end else if (b == epd_pkg::BYTE_STOP) begin
         result.valid = 1'b1;
         if (in_frame_ff) begin
            result.event_kind   = epd_pkg::EV_COMPLETE;
            result.frame_length = epd_pkg::report_len(count_ff);
            in_frame_in         = 1'b0;
            esc_in              = 1'b0;
            count_in            = '0;
         end else begin
            result.event_kind = epd_pkg::EV_STRAY_STOP;
         end
      end else if (in_frame_ff) begin
         if (esc_ff) begin
            esc_in       = 1'b0;
            result.valid = 1'b1;
            case (b)
               epd_pkg::CODE_START: begin
                  result.payload_byte = epd_pkg::BYTE_START;
                  count_in            = count_inc;
               end
               epd_pkg::CODE_ESC: begin
                  result.payload_byte = epd_pkg::BYTE_ESC;
                  count_in            = count_inc;
               end
               epd_pkg::CODE_STOP: begin
                  result.payload_byte = epd_pkg::BYTE_STOP;
                  count_in            = count_inc;
               end
               default: begin
                  result.event_kind = epd_pkg::EV_BAD_ESCAPE;
               end
            endcase
            if (result.event_kind == epd_pkg::EV_PAYLOAD) begin
               result.frame_length = epd_pkg::report_len(count_inc);
            end else begin
               result.frame_length = epd_pkg::report_len(count_ff);
            end
         end else if (b == epd_pkg::BYTE_ESC) begin
            esc_in = 1'b1;
         end else begin
            result.valid        = 1'b1;
            result.payload_byte = b;
            count_in            = count_inc;
            result.frame_length = epd_pkg::report_len(count_inc);
         end
      end
      // Only a held item counts
      if (!stage.valid) begin
         result.valid = 1'b0;
      end
   end

   // Commit the state only when the item advances
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         esc_ff      <= 1'b0;
         count_ff    <= '0;
      end else if (advance) begin
         in_frame_ff <= in_frame_in;
         esc_ff      <= esc_in;
         count_ff    <= count_in;
      end
   end

endmodule

// ===== hw/rtl/epd_out_stage.sv =====
module epd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  epd_pkg::result_type result,
   input  logic                advance,
   output logic                advance_ok,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [2:0]          out_kind,
   output logic [7:0]          out_payload,
   output logic [15:0]         out_length
);

   logic        valid_ff, valid_in;
   logic        load;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  payload_ff, payload_in;
   logic [15:0] length_ff, length_in;

   // Room for a new item once the held one is gone or leaving
   assign advance_ok = !valid_ff || out_ready;
   assign load       = advance && result.valid;

   always_comb begin
      valid_in   = valid_ff && !out_ready;
      kind_in    = kind_ff;
      payload_in = payload_ff;
      length_in  = length_ff;
      if (load) begin
         valid_in   = 1'b1;
         kind_in    = result.event_kind;
         payload_in = result.payload_byte;
         length_in  = result.frame_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      kind_ff    <= kind_in;
      payload_ff <= payload_in;
      length_ff  <= length_in;
   end

   assign out_valid   = valid_ff;
   assign out_kind    = kind_ff;
   assign out_payload = payload_ff;
   assign out_length  = length_ff;

endmodule

// ===== hw/rtl/escaped_packet_deframer_unit.sv =====
// Byte-stuffing deframer: takes one raw byte per item and returns at most one
// event per byte (payload byte, frame complete, abort by restart, stray stop or
// bad escape), in order. A byte passes an input register, is decoded
// combinationally against the frame/escape flags and the saturating length
// counter, and lands in the result register, which presents it until it is
// taken. One byte is accepted every cycle while the result side takes items;
// a held result that is not taken stops the input after the input register
// fills.
`include "assert_macros.svh"

module escaped_packet_deframer_unit (
   input  logic      clock,
   input  logic      reset,
   epd_req_if.sink   req,
   epd_rsp_if.source rsp
);

   epd_pkg::stage_type  stage;
   epd_pkg::result_type result;
   logic                advance;
   logic                advance_ok;

   epd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req.valid),
      .in_ready   (req.ready),
      .in_byte    (req.rx_byte),
      .advance_ok (advance_ok),
      .advance    (advance),
      .stage      (stage)
   );

   epd_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .advance (advance),
      .result  (result)
   );

   epd_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .result      (result),
      .advance     (advance),
      .advance_ok  (advance_ok),
      .out_valid   (rsp.valid),
      .out_ready   (rsp.ready),
      .out_kind    (rsp.event_kind),
      .out_payload (rsp.payload_byte),
      .out_length  (rsp.frame_length)
   );

   // Stray stops carry no length
   `EPD_ASSERT_NOW(a_stray_len, rsp.valid && rsp.event_kind == epd_pkg::EV_STRAY_STOP, rsp.frame_length == 16'h0000)
   // Only payload events carry a data byte
   `EPD_ASSERT_NOW(a_data_zero, rsp.valid && rsp.event_kind != epd_pkg::EV_PAYLOAD, rsp.payload_byte == 8'h00)
   // A payload byte always counts itself
   `EPD_ASSERT_NOW(a_payload_len, rsp.valid && rsp.event_kind == epd_pkg::EV_PAYLOAD, rsp.frame_length != 16'h0000)
   // A full input register with a stalled result blocks the input
   `EPD_ASSERT_NOW(a_block, stage.valid && rsp.valid && !rsp.ready, !req.ready)
   // A result loaded into the register is presented next cycle
   `EPD_ASSERT_NEXT(a_load, advance && result.valid, rsp.valid)

endmodule
